>>> hw/rtl/uvsti_pkg.sv
// shared types and constants for the uv sphere triangle index generator
`default_nettype none
package uvsti_pkg;

  localparam int CountWidth = 8;
  localparam int IndexWidth = 32;
  localparam int SumWidth   = 2 * CountWidth + 1;
  localparam int AddrWidth  = 4;
  localparam int DataWidth  = 32;

  localparam logic [CountWidth-1:0] RingCountReset    = CountWidth'(8);
  localparam logic [CountWidth-1:0] SegmentCountReset = CountWidth'(16);

  typedef enum logic [1:0] {
    REG_RING_COUNT    = 2'd0,
    REG_SEGMENT_COUNT = 2'd1,
    REG_BASE_VERTEX   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PART_CAP  = 2'd0,
    PART_BODY = 2'd1,
    PART_KEEL = 2'd2
  } part_t;

  typedef struct packed {
    logic [IndexWidth-1:0] corner_a;
    logic [IndexWidth-1:0] corner_b;
    logic [IndexWidth-1:0] corner_c;
    part_t                 part;
    logic                  final_triangle;
  } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/uv_sphere_triangle_index_generator.sv
// uv sphere triangle index generator: sequence counters, index math and output buffering
//
// Each transfer on the request channel (valid, stall, restart) produces one triangle
// on the result channel: three vertex indices with base_vertex added, the part code
// (top cap, body quad, bottom keel) and a flag on the last triangle of the sphere.
// restart = 1 begins again at the first cap triangle; otherwise the next triangle
// follows. After the final keel triangle the sequence starts over by itself.
// Throughput is one triangle per cycle while in_stall is low. The index math, one 8x8
// multiply and a few adds, lies between the sequence registers and the result register,
// or the skid register when that waits. A two-entry output buffer (result register plus
// skid register) keeps requests flowing while a result waits: stall rises only once both
// entries are full. ring_count, segment_count and base_vertex are written through the
// APB port; the user must write them only while the block is idle, which the block does
// not enforce. Reset (synchronous, active high) loads 8 rings, 16 segments, base 0,
// rewinds the sequence to the first cap triangle and empties the buffer.
`default_nettype none
module uv_sphere_triangle_index_generator
  import uvsti_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  // request channel
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   restart,
  // result channel
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [IndexWidth-1:0] corner_a,
  output logic [IndexWidth-1:0] corner_b,
  output logic [IndexWidth-1:0] corner_c,
  output logic [1:0]            part,
  output logic                  final_triangle,
  // configuration port
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [AddrWidth-1:0]  paddr,
  input  wire  [DataWidth-1:0]  pwdata,
  output logic [DataWidth-1:0]  prdata,
  output logic                  pready
);

  // configuration registers
  logic [CountWidth-1:0] ring_count;
  logic [CountWidth-1:0] segment_count;
  logic [IndexWidth-1:0] base_vertex;

  // sequence state
  part_t                 phase, phase_next;
  logic [CountWidth-1:0] ring_pos, ring_pos_next;
  logic [CountWidth-1:0] segment_pos, segment_pos_next;
  logic                  second_half, second_half_next;

  // output buffer
  result_t out_reg, skid_reg, result_next;
  logic    out_reg_valid, skid_valid;

  logic     cfg_write;
  cfg_reg_t cfg_sel;
  logic     in_fire, out_fire;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = cfg_reg_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_sel)
      REG_RING_COUNT:    prdata = DataWidth'(ring_count);
      REG_SEGMENT_COUNT: prdata = DataWidth'(segment_count);
      REG_BASE_VERTEX:   prdata = DataWidth'(base_vertex);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count    <= RingCountReset;
      segment_count <= SegmentCountReset;
      base_vertex   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_RING_COUNT:    ring_count    <= pwdata[CountWidth-1:0];
        REG_SEGMENT_COUNT: segment_count <= pwdata[CountWidth-1:0];
        REG_BASE_VERTEX:   base_vertex   <= pwdata[IndexWidth-1:0];
        default: ;
      endcase
    end
  end

  // position after a possible restart
  part_t                 cur_phase;
  logic [CountWidth-1:0] cur_ring, cur_seg;
  logic                  cur_half;
  logic [CountWidth-1:0] r_eff, s_eff, seg_nxt, mult_row;
  logic                  seg_end, last_body_ring;
  logic [2*CountWidth-1:0] row_prod;
  logic [SumWidth-1:0]   row, v_pos, v_nxt, v_pos_s, v_nxt_s, v_pole;
  logic [SumWidth-1:0]   va, vb, vc;
  logic                  fin;

  assign cur_phase = restart ? PART_CAP : phase;
  assign cur_ring  = restart ? '0 : ring_pos;
  assign cur_seg   = restart ? '0 : segment_pos;
  assign cur_half  = restart ? 1'b0 : second_half;

  // zero counts behave as one
  assign r_eff = (ring_count == '0) ? CountWidth'(1) : ring_count;
  assign s_eff = (segment_count == '0) ? CountWidth'(1) : segment_count;

  assign seg_end = ({1'b0, cur_seg} + (CountWidth+1)'(1)) >= {1'b0, s_eff};
  assign seg_nxt = seg_end ? '0 : cur_seg + CountWidth'(1);
  assign last_body_ring = ({1'b0, cur_ring} + (CountWidth+1)'(2)) >= {1'b0, r_eff};

  // ring whose first vertex anchors the triangle: cap uses ring 0, keel the last ring
  always_comb begin
    case (cur_phase)
      PART_CAP:  mult_row = '0;
      PART_BODY: mult_row = cur_ring;
      default:   mult_row = r_eff - CountWidth'(1);
    endcase
  end

  assign row_prod = {{CountWidth{1'b0}}, mult_row} * {{CountWidth{1'b0}}, s_eff};
  assign row      = SumWidth'(row_prod) + SumWidth'(1);
  assign v_pos    = row + SumWidth'(cur_seg);
  assign v_nxt    = row + SumWidth'(seg_nxt);
  assign v_pos_s  = v_pos + SumWidth'(s_eff);
  assign v_nxt_s  = v_nxt + SumWidth'(s_eff);
  assign v_pole   = row + SumWidth'(s_eff);

  always_comb begin
    phase_next       = cur_phase;
    ring_pos_next    = cur_ring;
    segment_pos_next = seg_end ? '0 : cur_seg + CountWidth'(1);
    second_half_next = cur_half;
    fin              = 1'b0;
    va               = v_pos;
    vb               = v_pole;
    vc               = v_nxt;
    case (cur_phase)
      PART_CAP: begin
        va = '0;
        vb = v_pos;
        vc = v_nxt;
        if (seg_end) begin
          ring_pos_next    = '0;
          second_half_next = 1'b0;
          phase_next       = (r_eff >= CountWidth'(2)) ? PART_BODY : PART_KEEL;
        end
      end
      PART_BODY: begin
        if (!cur_half) begin
          va               = v_pos;
          vb               = v_pos_s;
          vc               = v_nxt_s;
          second_half_next = 1'b1;
          segment_pos_next = cur_seg;
        end else begin
          va               = v_nxt_s;
          vb               = v_nxt;
          vc               = v_pos;
          second_half_next = 1'b0;
          if (seg_end) begin
            if (last_body_ring) begin
              phase_next    = PART_KEEL;
              ring_pos_next = '0;
            end else begin
              ring_pos_next = cur_ring + CountWidth'(1);
            end
          end
        end
      end
      default: begin
        // keel fan around the bottom pole, wraps to the first cap triangle
        if (seg_end) begin
          fin              = 1'b1;
          phase_next       = PART_CAP;
          ring_pos_next    = '0;
          second_half_next = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    result_next.corner_a       = base_vertex + IndexWidth'(va);
    result_next.corner_b       = base_vertex + IndexWidth'(vb);
    result_next.corner_c       = base_vertex + IndexWidth'(vc);
    result_next.part           = cur_phase;
    result_next.final_triangle = fin;
  end

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_reg_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PART_CAP;
      ring_pos      <= '0;
      segment_pos   <= '0;
      second_half   <= 1'b0;
      out_reg_valid <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase       <= phase_next;
        ring_pos    <= ring_pos_next;
        segment_pos <= segment_pos_next;
        second_half <= second_half_next;
        if (!out_reg_valid || out_fire) begin
          out_reg       <= result_next;
          out_reg_valid <= 1'b1;
        end else begin
          skid_reg   <= result_next;
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end else begin
          out_reg_valid <= 1'b0;
        end
      end
    end
  end

  assign out_valid      = out_reg_valid;
  assign corner_a       = out_reg.corner_a;
  assign corner_b       = out_reg.corner_b;
  assign corner_c       = out_reg.corner_c;
  assign part           = out_reg.part;
  assign final_triangle = out_reg.final_triangle;

  // skid entry is only ever filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_reg_valid)
    else $error("skid register holds a result while output register is empty");

  a_final_is_keel: assert property (@(posedge clk) disable iff (rst)
    out_reg_valid && out_reg.final_triangle |-> out_reg.part == PART_KEEL)
    else $error("final triangle flagged outside the keel");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_reg_valid)
    else $error("accepted request left no result");

  a_restart_cap: assert property (@(posedge clk) disable iff (rst)
    in_fire && restart && (!out_reg_valid || out_fire) |=>
      out_reg.part == PART_CAP && out_reg.corner_a == base_vertex)
    else $error("restart did not produce the first cap triangle");

endmodule
`default_nettype wire
